// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the bank decoder.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BMMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BMMD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bmmd_pkg.sv =====
// Types and constants of the banked memory map decoder.
// Depends on nothing; used by the interfaces, the top level and the checker.
package bmmd_pkg;

    typedef enum logic [2:0] {
        TGT_ROM  = 3'd0,
        TGT_VRAM = 3'd1,
        TGT_CRAM = 3'd2,
        TGT_WRAM = 3'd3,
        TGT_OAM  = 3'd4,
        TGT_IO   = 3'd5,
        TGT_NONE = 3'd6
    } target_t;

    typedef enum logic [1:0] {
        CFG_CONTROLLER_ON = 2'd0,
        CFG_ROM_BANK_MASK = 2'd1,
        CFG_RAM_BANK_CNT  = 2'd2,
        CFG_CART_RAM      = 2'd3
    } cfg_index_t;

    localparam int CfgDataWidth = 7;
    localparam int AddrWidth    = 16;
    localparam int OffsetWidth  = 21;

    localparam logic [6:0] RomBankReset   = 7'd1;
    localparam logic [6:0] RomMaskReset   = 7'h7F;
    localparam logic [3:0] RamEnableKey   = 4'hA;

    typedef struct packed {
        target_t                 target;
        logic [OffsetWidth-1:0]  phys_offset;
        logic                    store_enable;
        logic [7:0]              store_data;
    } result_t;

endpackage

// ===== sv/bmmd_if.sv =====
// Handshake channels of the bank decoder: CPU access in, decoded result out.
// Depends on bmmd_pkg for widths and the target code type.
interface bmmd_access_if
    import bmmd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [AddrWidth-1:0]  bus_address;
    logic [7:0]            write_value;

    modport source (output valid, output cmd, output bus_address, output write_value,
                    input ready);
    modport sink   (input valid, input cmd, input bus_address, input write_value,
                    output ready);
endinterface

interface bmmd_result_if
    import bmmd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    target_t                 target;
    logic [OffsetWidth-1:0]  phys_offset;
    logic                    store_enable;
    logic [7:0]              store_data;

    modport source (output valid, output target, output phys_offset,
                    output store_enable, output store_data, input ready);
    modport sink   (input valid, input target, input phys_offset,
                    input store_enable, input store_data, output ready);
endinterface

// ===== sv/banked_memory_map_decoder.sv =====
// Banked memory map decoder: each accepted access is decoded combinationally and its result
// is registered in the output register, or in the skid entry while the output stalls.
// Throughput one access per cycle while the skid entry is empty; bank registers update at
// the accepting edge. The two-entry buffer takes one more access while a result waits.
// rst_n is asynchronous, active low: config to defaults, ROM bank 1, other bank state 0,
// result buffer empty.
module banked_memory_map_decoder
    import bmmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    bmmd_access_if.sink              access_ch,
    bmmd_result_if.source            result_ch
);

    // Configuration registers: the user writes them only while the block is idle (not enforced).
    logic        ctrl_on_reg;
    logic [6:0]  rom_mask_reg;
    logic [4:0]  ram_bank_cnt_reg;
    logic        cart_ram_reg;

    // Bank controller state.
    logic [6:0]  rom_bank_reg,  rom_bank_next;
    logic [1:0]  ram_bank_reg,  ram_bank_next;
    logic        ram_en_reg,    ram_en_next;
    logic        bank_mode_reg, bank_mode_next;

    // Result buffer: the output register and a skid entry behind it.
    result_t     out_reg,   out_next;
    logic        out_valid_reg, out_valid_next;
    result_t     skid_reg,  skid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        in_fire;
    logic        out_fire;
    result_t     decoded;

    logic                   cmd;
    logic [AddrWidth-1:0]   addr;
    logic [7:0]             wval;

    assign cmd  = access_ch.cmd;
    assign addr = access_ch.bus_address;
    assign wval = access_ch.write_value;

    // The skid entry is the only thing that can block a new access.
    assign access_ch.ready = !skid_valid_reg;
    assign in_fire  = access_ch.valid && access_ch.ready;
    assign out_fire = out_valid_reg && result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_on_reg      <= 1'b0;
            rom_mask_reg     <= RomMaskReset;
            ram_bank_cnt_reg <= 5'd0;
            cart_ram_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CONTROLLER_ON: ctrl_on_reg      <= cfg_data[0];
                CFG_ROM_BANK_MASK: rom_mask_reg     <= cfg_data[6:0];
                CFG_RAM_BANK_CNT:  ram_bank_cnt_reg <= cfg_data[4:0];
                CFG_CART_RAM:      cart_ram_reg     <= cfg_data[0];
                default:           ctrl_on_reg      <= ctrl_on_reg;
            endcase
        end
    end

    // Address decode against the bank state in force before this access.
    always_comb
    begin
        decoded.target       = TGT_NONE;
        decoded.phys_offset  = '0;
        case (addr) inside
            [16'h0000:16'h3FFF]:
            begin
                decoded.target      = TGT_ROM;
                decoded.phys_offset = {7'd0, addr[13:0]};
            end
            [16'h4000:16'h7FFF]:
            begin
                // Switchable window: the full seven-bit bank in every mode.
                decoded.target      = TGT_ROM;
                decoded.phys_offset = {rom_bank_reg, addr[13:0]};
            end
            [16'h8000:16'h9FFF]:
            begin
                decoded.target      = TGT_VRAM;
                decoded.phys_offset = {8'd0, addr[12:0]};
            end
            [16'hA000:16'hBFFF]:
            begin
                // Cartridge RAM only answers when fitted and enabled.
                if (cart_ram_reg && ram_en_reg)
                begin
                    decoded.target = TGT_CRAM;
                    if (ctrl_on_reg && bank_mode_reg
                        && ({3'd0, ram_bank_reg} < ram_bank_cnt_reg))
                    begin
                        decoded.phys_offset = {6'd0, ram_bank_reg, addr[12:0]};
                    end
                    else
                    begin
                        decoded.phys_offset = {8'd0, addr[12:0]};
                    end
                end
            end
            [16'hC000:16'hFDFF]:
            begin
                // Work RAM and its echo share the low thirteen address bits.
                decoded.target      = TGT_WRAM;
                decoded.phys_offset = {8'd0, addr[12:0]};
            end
            [16'hFE00:16'hFE9F]:
            begin
                decoded.target      = TGT_OAM;
                decoded.phys_offset = {13'd0, addr[7:0]};
            end
            [16'hFF00:16'hFFFF]:
            begin
                decoded.target      = TGT_IO;
                decoded.phys_offset = {13'd0, addr[7:0]};
            end
            default:
            begin
                decoded.target      = TGT_NONE;
                decoded.phys_offset = '0;
            end
        endcase

        // ROM-area writes go to the controller; writes to nothing are dropped.
        decoded.store_enable = cmd && !addr[15] && 1'b0;
        if (cmd && addr[15] && (decoded.target != TGT_NONE))
        begin
            decoded.store_enable = 1'b1;
        end
        decoded.store_data = decoded.store_enable ? wval : 8'd0;
    end

    // Bank controller register update on ROM-area writes.
    always_comb
    begin
        rom_bank_next  = rom_bank_reg;
        ram_bank_next  = ram_bank_reg;
        ram_en_next    = ram_en_reg;
        bank_mode_next = bank_mode_reg;
        if (in_fire && cmd && !addr[15] && ctrl_on_reg)
        begin
            case (addr[14:13])
                2'd0: ram_en_next = (wval[3:0] == RamEnableKey);
                2'd1:
                begin
                    // A zero low field is replaced by one before the mask is applied.
                    if (wval[4:0] == 5'd0)
                    begin
                        rom_bank_next = {rom_bank_reg[6:5], 5'd1} & rom_mask_reg;
                    end
                    else
                    begin
                        rom_bank_next = {rom_bank_reg[6:5], wval[4:0]} & rom_mask_reg;
                    end
                end
                2'd2:
                begin
                    ram_bank_next = wval[1:0];
                    rom_bank_next = {wval[1:0], rom_bank_reg[4:0]} & rom_mask_reg;
                end
                default: bank_mode_next = wval[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg  <= RomBankReset;
            ram_bank_reg  <= 2'd0;
            ram_en_reg    <= 1'b0;
            bank_mode_reg <= 1'b0;
        end
        else
        begin
            rom_bank_reg  <= rom_bank_next;
            ram_bank_reg  <= ram_bank_next;
            ram_en_reg    <= ram_en_next;
            bank_mode_reg <= bank_mode_next;
        end
    end

    // Result buffer. When the output register drains (or is empty) it refills from
    // the skid entry first, else from the new access. A new access that arrives
    // while the output stalls is parked in the skid entry.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = decoded;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_next       = decoded;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.target       = out_reg.target;
    assign result_ch.phys_offset  = out_reg.phys_offset;
    assign result_ch.store_enable = out_reg.store_enable;
    assign result_ch.store_data   = out_reg.store_data;

endmodule

// ===== sv/bmmd_checker.sv =====
// Port-level checks of the bank decoder, attached to the top level by bind.
// Depends on bmmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmmd_checker
    import bmmd_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input target_t                 target,
    input logic [OffsetWidth-1:0]  phys_offset,
    input logic                    store_enable,
    input logic [7:0]              store_data
);

    // A stalled result stays offered with its target, offset and data unchanged.
    `BMMD_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(target) && $stable(phys_offset) && $stable(store_data),
        "stalled result changed")

    // Backpressure on the access side only comes from a full result buffer.
    `BMMD_ASSERT_IMP(a_ready_full, clk, rst_n, !in_ready, out_valid,
        "access side blocked with an empty result register")

    // Stores never go to ROM or to an unmapped target.
    `BMMD_ASSERT_IMP(a_store_target, clk, rst_n, out_valid && store_enable,
        target != TGT_ROM && target != TGT_NONE, "store to ROM or unmapped area")

    // No store means no data, and an unmapped target carries no offset.
    `BMMD_ASSERT_IMP(a_quiet_fields, clk, rst_n, out_valid && !store_enable,
        store_data == 8'd0 && (target != TGT_NONE || phys_offset == '0),
        "idle fields not cleared")

endmodule

bind banked_memory_map_decoder bmmd_checker u_bmmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (access_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .target       (result_ch.target),
    .phys_offset  (result_ch.phys_offset),
    .store_enable (result_ch.store_enable),
    .store_data   (result_ch.store_data)
);

// ===== verif/tb.sv =====
// Self-checking testbench for banked_memory_map_decoder: CPU accesses in, decoded targets out.
// Depends on bmmd_pkg, the bmmd_access_if and bmmd_result_if interfaces and the top level.
module tb;
    import bmmd_pkg::*;

    // Window boundaries of the CPU address map.
    localparam logic [15:0] WinRomBanked = 16'h4000;
    localparam logic [15:0] WinVram      = 16'h8000;
    localparam logic [15:0] WinCram      = 16'hA000;
    localparam logic [15:0] WinWram      = 16'hC000;
    localparam logic [15:0] WinEcho      = 16'hE000;
    localparam logic [15:0] WinOam       = 16'hFE00;
    localparam logic [15:0] WinUnused    = 16'hFEA0;
    localparam logic [15:0] WinIo        = 16'hFF00;

    // Bank controller register regions inside the ROM area.
    localparam logic [15:0] RegRomLow  = 16'h2000;
    localparam logic [15:0] RegRamBank = 16'h4000;
    localparam logic [15:0] RegMode    = 16'h6000;

    // One CPU bus access as the sender sees it.
    typedef struct packed {
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  value;
    } bus_access_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [1:0]              cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    bmmd_access_if acc ();
    bmmd_result_if res ();

    banked_memory_map_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .access_ch (acc),
        .result_ch (res)
    );

    // Our own copy of the configuration registers.
    logic       cfg_mbc_on;
    logic [6:0] cfg_rom_mask;
    logic [4:0] cfg_ram_banks;
    logic       cfg_has_ram;

    // Our own copy of the bank controller state.
    logic [6:0] mbc_rom_bank;
    logic [1:0] mbc_ram_bank;
    logic       mbc_ram_on;
    logic       mbc_mode;

    bus_access_t bus_accesses[$];     // accesses still to be offered to the block
    result_t     expected_decodes[$]; // decodes predicted for accepted accesses

    bus_access_t drv_access;
    logic        steady;              // when set, neither side idles
    int unsigned error_count;
    int unsigned n_sent;
    int unsigned n_writes;
    int unsigned n_checked;
    int unsigned n_settings;

    // A write into the ROM area updates the bank controller, but only when the
    // controller is fitted. The zero-to-one fixup looks at the low five bits only,
    // and the mask is applied afterwards, so a small mask can still give bank 0.
    function automatic void update_bank_regs(input logic [15:0] a, input logic [7:0] v);
        logic [6:0] sel;
        if (cfg_mbc_on)
        begin
            if (a < RegRomLow)
            begin
                mbc_ram_on = (v[3:0] == RamEnableKey);
            end
            else if (a < RegRamBank)
            begin
                sel = {mbc_rom_bank[6:5], v[4:0]};
                if (sel[4:0] == 5'd0)
                    sel = sel + 7'd1;
                mbc_rom_bank = sel & cfg_rom_mask;
            end
            else if (a < RegMode)
            begin
                mbc_ram_bank = v[1:0];
                mbc_rom_bank = {v[1:0], mbc_rom_bank[4:0]} & cfg_rom_mask;
            end
            else
            begin
                mbc_mode = v[0];
            end
        end
    endfunction

    // Decodes one access against the current bank state and, for writes,
    // applies its effect. The offset of a ROM-area write comes from the bank
    // in force before the write.
    function automatic result_t decode_access(input logic wr, input logic [15:0] a,
                                              input logic [7:0] v);
        result_t r;
        r.target       = TGT_NONE;
        r.phys_offset  = '0;
        r.store_enable = 1'b0;
        r.store_data   = 8'd0;
        if (a < WinRomBanked)
        begin
            r.target      = TGT_ROM;
            r.phys_offset = {5'd0, a};
        end
        else if (a < WinVram)
        begin
            // The switchable window always uses the whole seven-bit bank.
            r.target      = TGT_ROM;
            r.phys_offset = {mbc_rom_bank, a[13:0]};
        end
        else if (a < WinCram)
        begin
            r.target      = TGT_VRAM;
            r.phys_offset = {8'd0, a[12:0]};
        end
        else if (a < WinWram)
        begin
            // Cartridge RAM that is absent or disabled reads as nothing.
            if (cfg_has_ram && mbc_ram_on)
            begin
                r.target = TGT_CRAM;
                if (cfg_mbc_on && mbc_mode && ({3'd0, mbc_ram_bank} < cfg_ram_banks))
                    r.phys_offset = {6'd0, mbc_ram_bank, a[12:0]};
                else
                    r.phys_offset = {8'd0, a[12:0]};
            end
        end
        else if (a < WinOam)
        begin
            // Work RAM and its echo both map onto the low 8 KiB.
            r.target      = TGT_WRAM;
            r.phys_offset = {8'd0, a[12:0]};
        end
        else if (a < WinUnused)
        begin
            r.target      = TGT_OAM;
            r.phys_offset = {13'd0, a[7:0]};
        end
        else if (a >= WinIo)
        begin
            r.target      = TGT_IO;
            r.phys_offset = {13'd0, a[7:0]};
        end
        if (wr)
        begin
            if (a < WinVram)
            begin
                update_bank_regs(a, v);
            end
            else if (r.target != TGT_NONE)
            begin
                r.store_enable = 1'b1;
                r.store_data   = v;
            end
        end
        return r;
    endfunction

    // Draws one access. Most of them aim at the parts of the map that depend on
    // the bank state: controller writes, the cartridge RAM window, the switchable
    // ROM window and the edges between windows. The rest is fully random.
    function automatic bus_access_t random_access();
        bus_access_t t;
        int unsigned pick;
        logic [15:0] base;
        pick    = $urandom_range(99);
        t.cmd   = 1'($urandom_range(1));
        t.addr  = 16'($urandom_range(16'hFFFF));
        t.value = 8'($urandom_range(255));
        base    = 16'h0000;
        if (pick < 25)
        begin
            t.cmd     = 1'b1;
            t.addr[15] = 1'b0;
            if (t.addr < RegRomLow && $urandom_range(1) == 1)
                t.value[3:0] = RamEnableKey;
            if ($urandom_range(3) == 0)
                t.value[4:0] = 5'd0;
        end
        else if (pick < 45)
        begin
            t.addr[15:13] = 3'b101;
        end
        else if (pick < 58)
        begin
            t.addr[15:14] = 2'b01;
        end
        else if (pick < 70)
        begin
            case ($urandom_range(10))
                0:       base = RegRomLow;
                1:       base = RegRamBank;
                2:       base = RegMode;
                3:       base = WinVram;
                4:       base = WinCram;
                5:       base = WinWram;
                6:       base = WinEcho;
                7:       base = WinOam;
                8:       base = WinUnused;
                9:       base = WinIo;
                default: base = 16'h0000;
            endcase
            t.addr = base - 16'($urandom_range(1));
        end
        return t;
    endfunction

    task automatic queue_access(input logic c, input logic [15:0] a, input logic [7:0] v);
        bus_access_t t;
        t.cmd   = c;
        t.addr  = a;
        t.value = v;
        bus_accesses.push_back(t);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch on result %0d: %s is %0h, expected %0h", n_checked, what, got, want);
        error_count++;
    endtask

    // Waits until every queued access went out and every predicted decode came
    // back, then lets the pipeline settle before going on.
    task automatic wait_drained();
        while (bus_accesses.size() != 0 || acc.valid || expected_decodes.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Register writes happen only while the block is idle, so the model copy
    // can be updated right away.
    task automatic write_reg(input cfg_index_t idx, input logic [6:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_CONTROLLER_ON: cfg_mbc_on    = val[0];
            CFG_ROM_BANK_MASK: cfg_rom_mask  = val;
            CFG_RAM_BANK_CNT:  cfg_ram_banks = val[4:0];
            CFG_CART_RAM:      cfg_has_ram   = val[0];
            default:           ;
        endcase
    endtask

    task automatic apply_setting(input logic on, input logic [6:0] mask,
                                 input logic [4:0] banks, input logic has_ram);
        wait_drained();
        write_reg(CFG_CONTROLLER_ON, {6'd0, on});
        write_reg(CFG_ROM_BANK_MASK, mask);
        write_reg(CFG_RAM_BANK_CNT, {2'd0, banks});
        write_reg(CFG_CART_RAM, {6'd0, has_ram});
        n_settings++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sender. A transfer seen at this edge is predicted first; then the next
    // access is offered, unless the sender idles this cycle. Valid is assigned
    // once per edge, so a back-to-back access keeps it high.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc.valid       <= 1'b0;
            acc.cmd         <= 1'b0;
            acc.bus_address <= '0;
            acc.write_value <= 8'd0;
        end
        else
        begin
            if (acc.valid && acc.ready)
            begin
                expected_decodes.push_back(decode_access(acc.cmd, acc.bus_address,
                                                         acc.write_value));
                n_sent++;
                if (acc.cmd)
                    n_writes++;
            end
            if (!acc.valid || acc.ready)
            begin
                if (bus_accesses.size() != 0 && (steady || $urandom_range(99) >= 38))
                begin
                    drv_access       = bus_accesses.pop_front();
                    acc.valid       <= 1'b1;
                    acc.cmd         <= drv_access.cmd;
                    acc.bus_address <= drv_access.addr;
                    acc.write_value <= drv_access.value;
                end
                else
                begin
                    acc.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Each result transfer is checked field by field against the
    // oldest predicted decode; ready stalls at random except in steady stretches.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_decodes.size() == 0)
                begin
                    report_mismatch("result with no access outstanding, target",
                                    32'(res.target), 0);
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    if (res.target !== want.target)
                        report_mismatch("target", 32'(res.target), 32'(want.target));
                    if (res.phys_offset !== want.phys_offset)
                        report_mismatch("phys_offset", 32'(res.phys_offset),
                                        32'(want.phys_offset));
                    if (res.store_enable !== want.store_enable)
                        report_mismatch("store_enable", 32'(res.store_enable),
                                        32'(want.store_enable));
                    if (res.store_data !== want.store_data)
                        report_mismatch("store_data", 32'(res.store_data),
                                        32'(want.store_data));
                end
                n_checked++;
            end
            res.ready <= steady || ($urandom_range(99) >= 38);
        end
    end

    // Stimulus and run control.
    initial
    begin
        int unsigned i;
        int unsigned j;
        logic [6:0]  mask;
        acc.valid       = 1'b0;
        acc.cmd         = 1'b0;
        acc.bus_address = '0;
        acc.write_value = 8'd0;
        res.ready       = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        steady          = 1'b0;
        error_count     = 0;
        n_sent          = 0;
        n_writes        = 0;
        n_checked       = 0;
        n_settings      = 0;

        // Reset values of the registers and of the bank state.
        cfg_mbc_on    = 1'b0;
        cfg_rom_mask  = RomMaskReset;
        cfg_ram_banks = 5'd0;
        cfg_has_ram   = 1'b0;
        mbc_rom_bank  = RomBankReset;
        mbc_ram_bank  = 2'd0;
        mbc_ram_on    = 1'b0;
        mbc_mode      = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed, with the reset settings: no controller and no cartridge RAM,
        // so the bank write is dropped and the cartridge window reads as nothing.
        queue_access(1'b0, 16'h0000, 8'h00);
        queue_access(1'b0, 16'h7FFF, 8'hFF);
        queue_access(1'b1, 16'h2000, 8'h00);
        queue_access(1'b0, 16'hA000, 8'h00);
        queue_access(1'b1, 16'hFEA0, 8'hFF);
        queue_access(1'b0, 16'hFFFF, 8'h00);

        // Directed, with the controller fitted: RAM enable by key, banking mode, RAM
        // bank selection, the zero-to-one fixup, stores in the VRAM, WRAM, echo, OAM
        // and I/O windows and RAM disabled by a value whose low nibble is not the key.
        apply_setting(1'b1, 7'h7F, 5'd4, 1'b1);
        queue_access(1'b1, 16'h0000, 8'h0A);
        queue_access(1'b0, 16'hA000, 8'h00);
        queue_access(1'b1, 16'h6000, 8'h01);
        queue_access(1'b1, 16'h4000, 8'h02);
        queue_access(1'b0, 16'hBFFF, 8'h00);
        queue_access(1'b1, 16'h2000, 8'h00);
        queue_access(1'b0, 16'h4000, 8'h00);
        queue_access(1'b1, 16'h3FFF, 8'hFF);
        queue_access(1'b0, 16'h7FFF, 8'h00);
        queue_access(1'b1, 16'h9FFF, 8'hA5);
        queue_access(1'b1, 16'hC000, 8'h01);
        queue_access(1'b1, 16'hE000, 8'h5A);
        queue_access(1'b1, 16'hFDFF, 8'h80);
        queue_access(1'b1, 16'hFE9F, 8'h7F);
        queue_access(1'b1, 16'hFF00, 8'hFF);
        queue_access(1'b1, 16'h1FFF, 8'h1B);
        queue_access(1'b0, 16'hA000, 8'h00);
        queue_access(1'b1, 16'h0000, 8'hFA);

        // Random part, first with neither side idling at all.
        apply_setting(1'b1, 7'h7F, 5'd4, 1'b1);
        steady = 1'b1;
        for (i = 0; i < 60; i++)
            bus_accesses.push_back(random_access());
        wait_drained();
        steady = 1'b0;

        // A zero mask forces every bank write to ROM bank 0, and no RAM bank is ever in range.
        apply_setting(1'b1, 7'h00, 5'd0, 1'b1);
        for (i = 0; i < 40; i++)
            bus_accesses.push_back(random_access());

        // Largest bank count; the sender holds off until the block has drained
        // after every few accesses.
        apply_setting(1'b1, 7'h1F, 5'd16, 1'b1);
        for (j = 0; j < 4; j++)
        begin
            for (i = 0; i < 10; i++)
                bus_accesses.push_back(random_access());
            wait_drained();
        end

        // Controller absent: bank writes must have no effect.
        apply_setting(1'b0, 7'h7F, 5'd16, 1'b1);
        for (i = 0; i < 40; i++)
            bus_accesses.push_back(random_access());

        // No cartridge RAM at all.
        apply_setting(1'b1, 7'h03, 5'd1, 1'b0);
        for (i = 0; i < 40; i++)
            bus_accesses.push_back(random_access());

        // A few random settings, mostly with the controller fitted.
        for (j = 0; j < 4; j++)
        begin
            case ($urandom_range(7))
                0:       mask = 7'h01;
                1:       mask = 7'h03;
                2:       mask = 7'h07;
                3:       mask = 7'h0F;
                4:       mask = 7'h1F;
                5:       mask = 7'h3F;
                6:       mask = 7'h7F;
                default: mask = 7'($urandom_range(127));
            endcase
            apply_setting($urandom_range(3) != 0, mask, 5'($urandom_range(16)),
                          $urandom_range(3) != 0);
            for (i = 0; i < 45; i++)
                bus_accesses.push_back(random_access());
        end

        wait_drained();
        repeat (5) @(posedge clk);
        if (expected_decodes.size() != 0)
            report_mismatch("decodes never delivered, count", expected_decodes.size(), 0);

        $display("Covered %0d accesses (%0d writes) under %0d register settings;",
                 n_sent, n_writes, n_settings);
        $display("%0d decoded results were compared.", n_checked);
        if (error_count == 0)
            $display("[banked_memory_map_decoder] OK");
        else
            $display("[banked_memory_map_decoder] ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("watchdog expired with %0d accesses queued and %0d results outstanding",
                 bus_accesses.size(), expected_decodes.size());
        $display("[banked_memory_map_decoder] ERROR");
        $finish;
    end

endmodule

// ===== banked_memory_map_decoder.f =====
+incdir+sv
sv/bmmd_pkg.sv
sv/bmmd_if.sv
sv/banked_memory_map_decoder.sv
sv/bmmd_checker.sv
verif/tb.sv
